// ===== hdl/cfdec_pkg.sv =====
// Shared types, codes and sizing constants of the run-length frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package cfdec_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 1024;

  // Column counter holds 0..MAX_WIDTH, row counter holds 0..MAX_ROWS-1.
  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  // Column sum must hold a full line plus the longest run of 128.
  localparam int SUM_W = ((COL_W > 8) ? COL_W : 8) + 1;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIPPED_MODE = 1'd1;

  localparam logic [10:0] FRAME_WIDTH_RESET = 11'd32;
  localparam logic [7:0] CTRL_LITERAL_MAX = 8'h7F;
  localparam logic [7:0] CTRL_ZERO = 8'h00;
  localparam logic [15:0] MIN_DATA_OFFSET = 16'd2;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_HDR_HIGH = 3'd1,
    PH_SKIP     = 3'd2,
    PH_CTRL     = 3'd3,
    PH_LIT      = 3'd4,
    PH_ERR      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_COLOR = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_COUNT = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_TRUNCATED  = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    kind_t      item_kind;
    logic [7:0] color_index;
    logic [7:0] run_length;
    logic [9:0] row_index;
    logic       line_end;
    logic       frame_end;
    status_t    status;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/cfdec_in_stage.sv =====
// Input register of the decoder: holds one accepted byte until decode takes it.
`timescale 1ns / 1ps
`default_nettype none
module cfdec_in_stage
  import cfdec_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire in_beat_t s_beat,
  output logic          held_valid,
  output in_beat_t      held_beat,
  input  wire logic     consume
);

  // The register may refill in the same cycle that decode consumes it.
  assign s_tready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held_beat <= s_beat;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cfdec_decode.sv =====
// Frame decode: configuration registers, frame state and the per-byte decision.
`timescale 1ns / 1ps
`default_nettype none
module cfdec_decode
  import cfdec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  held_valid,
  input  wire in_beat_t              held_beat,
  output logic                       consume,
  input  wire logic                  out_space,
  output logic                       res_load,
  output result_t                    res
);

  logic [10:0] frame_width;
  logic        clipped_mode;

  phase_t           phase, phase_next;
  logic [7:0]       offset_low_byte, offset_low_byte_next;
  logic [15:0]      byte_position, byte_position_next;
  logic [15:0]      data_start, data_start_next;
  logic [6:0]       literal_remaining, literal_remaining_next;
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;

  logic [COL_W-1:0] eff_width;
  logic             emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      clipped_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width <= cfg_data[10:0];
        CFG_CLIPPED_MODE: clipped_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == 11'd0) begin
      eff_width = COL_W'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_width = COL_W'(MAX_WIDTH);
    end else begin
      eff_width = COL_W'(frame_width);
    end
  end

  always_comb begin
    logic             ctrl;
    logic             add_en;
    logic             add_color;
    logic             group_end;
    logic [7:0]       add_n;
    logic [7:0]       b;
    logic [15:0]      offset;
    logic [15:0]      pos_inc;
    logic [6:0]       lit_dec;
    logic [SUM_W-1:0] col_sum;

    b = held_beat.data_byte;
    ctrl = 1'b0;
    add_en = 1'b0;
    add_color = 1'b0;
    group_end = 1'b0;
    add_n = 8'd0;
    offset = 16'd0;
    pos_inc = byte_position + 16'd1;
    lit_dec = literal_remaining - 7'd1;
    col_sum = '0;

    phase_next = phase;
    offset_low_byte_next = offset_low_byte;
    byte_position_next = byte_position;
    data_start_next = data_start;
    literal_remaining_next = literal_remaining;
    column_count_next = column_count;
    row_count_next = row_count;

    emit = 1'b0;
    res.item_kind = KIND_NONE;
    res.color_index = 8'd0;
    res.run_length = 8'd0;
    res.row_index = 10'(row_count);
    res.line_end = 1'b0;
    res.frame_end = held_beat.last_byte;
    res.status = ST_OK;

    case (phase)
      PH_START: begin
        if (clipped_mode) begin
          offset_low_byte_next = b;
          byte_position_next = 16'd1;
          phase_next = PH_HDR_HIGH;
        end else begin
          ctrl = 1'b1;
        end
      end
      PH_HDR_HIGH: begin
        offset = {b, offset_low_byte};
        if (offset < MIN_DATA_OFFSET) begin
          offset = MIN_DATA_OFFSET;
        end
        data_start_next = offset;
        byte_position_next = 16'd2;
        phase_next = (offset == MIN_DATA_OFFSET) ? PH_CTRL : PH_SKIP;
      end
      PH_SKIP: begin
        byte_position_next = pos_inc;
        if (pos_inc >= data_start) begin
          phase_next = PH_CTRL;
        end
      end
      PH_CTRL: begin
        ctrl = 1'b1;
      end
      PH_LIT: begin
        literal_remaining_next = lit_dec;
        add_en = 1'b1;
        add_color = 1'b1;
        add_n = 8'd1;
        group_end = (lit_dec == 7'd0);
      end
      default: ;
    endcase

    if (ctrl) begin
      phase_next = PH_CTRL;
      if (b > CTRL_LITERAL_MAX) begin
        // Two's complement of the byte is 256 minus it: 1..128.
        add_en = 1'b1;
        add_n = 8'd0 - b;
        group_end = 1'b1;
      end else if (b == CTRL_ZERO) begin
        emit = 1'b1;
        res.status = ST_ZERO_COUNT;
      end else begin
        literal_remaining_next = b[6:0];
        phase_next = PH_LIT;
      end
    end

    if (add_en) begin
      emit = 1'b1;
      col_sum = SUM_W'(column_count) + SUM_W'(add_n);
      if (col_sum > SUM_W'(eff_width)) begin
        res.status = ST_OVERFLOW;
        phase_next = PH_ERR;
      end else begin
        column_count_next = COL_W'(col_sum);
        if (group_end && col_sum == SUM_W'(eff_width)) begin
          res.line_end = 1'b1;
          column_count_next = '0;
          if (32'(row_count) < MAX_ROWS - 1) begin
            row_count_next = row_count + ROW_W'(1);
          end
        end
        if (add_color) begin
          res.item_kind = KIND_COLOR;
          res.color_index = b;
          res.run_length = 8'd1;
          if (lit_dec == 7'd0) begin
            phase_next = PH_CTRL;
          end
        end else begin
          res.item_kind = KIND_RUN;
          res.run_length = add_n;
        end
      end
    end

    if (held_beat.last_byte) begin
      emit = 1'b1;
      if (phase_next == PH_ERR) begin
        res.status = ST_OVERFLOW;
      end else if (phase_next == PH_LIT) begin
        res.status = ST_TRUNCATED;
      end else if (phase_next == PH_CTRL && column_count_next != '0) begin
        res.status = ST_INCOMPLETE;
      end
      phase_next = PH_START;
      offset_low_byte_next = 8'd0;
      byte_position_next = 16'd0;
      data_start_next = 16'd0;
      literal_remaining_next = 7'd0;
      column_count_next = '0;
      row_count_next = '0;
    end
  end

  // A byte that gives no result never waits for the output register.
  assign consume  = held_valid && (!emit || out_space);
  assign res_load = held_valid && emit && out_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      offset_low_byte <= 8'd0;
      byte_position <= 16'd0;
      data_start <= 16'd0;
      literal_remaining <= 7'd0;
      column_count <= '0;
      row_count <= '0;
    end else if (consume) begin
      phase <= phase_next;
      offset_low_byte <= offset_low_byte_next;
      byte_position <= byte_position_next;
      data_start <= data_start_next;
      literal_remaining <= literal_remaining_next;
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

  a_last_clears_frame: assert property (@(posedge clk) disable iff (rst)
    consume && held_beat.last_byte |=>
      phase == PH_START && column_count == '0 && row_count == '0)
    else $error("frame state not cleared after last byte");

  a_literal_pending: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LIT |-> literal_remaining != 7'd0)
    else $error("literal phase with no bytes pending");

  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    consume && emit |-> out_space && res_load)
    else $error("result produced without room in output register");

endmodule
`default_nettype wire

// ===== hdl/cfdec_out_stage.sv =====
// Result register of the decoder: holds one result beat until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module cfdec_out_stage
  import cfdec_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_load,
  input  wire result_t res,
  output logic         out_space,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output result_t      m_res
);

  // Room whenever empty or the held beat leaves this cycle.
  assign out_space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_space) begin
      m_tvalid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_space && res_load) begin
      m_res <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cel_frame_rle_decoder_unit.sv =====
// Top level of the run-length sprite frame decoder.
//
// Encoded frame bytes enter on the s_ stream, one byte per beat, with s_tlast on
// the final byte of a frame. Each byte gives zero or one result beat on the m_
// stream: a transparent run, a color pixel, or a status-only beat. m_tlast marks
// the result of the frame's last byte. Frame width and header mode are written
// through cfg_we/cfg_index/cfg_data between frames; the header mode is taken at
// the first byte of each frame.
// The path is an input register, one level of decode logic and a result register,
// so a result beat is decoded from its byte in the input register and loaded into
// the result register, and one byte is taken every cycle while the receiver keeps
// up. Bytes that give no result (header, skipped and literal-count bytes, bytes
// dropped after an error) pass decode without waiting for the result register.
// Reset clears both stream registers and the frame state; the width returns to 32
// and the header mode to off. When the receiver holds m_tready low the result
// register keeps its beat, decode stops on the next byte that has a result, and
// s_tready falls once the input register is also full.
`timescale 1ns / 1ps
`default_nettype none
module cel_frame_rle_decoder_unit
  import cfdec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // data_byte
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // color_index[7:0], run_length[15:8], row_index[25:16], line_end[26],
  // status[29:27], zero fill[31:30]
  output logic [31:0]                m_tdata,
  output logic [1:0]                 m_tuser,   // item_kind
  output logic                       m_tlast
);

  in_beat_t s_beat;
  in_beat_t held_beat;
  logic     held_valid;
  logic     consume;
  logic     out_space;
  logic     res_load;
  result_t  res;
  result_t  m_res;

  assign s_beat.data_byte = s_tdata;
  assign s_beat.last_byte = s_tlast;

  cfdec_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_beat     (s_beat),
    .held_valid (held_valid),
    .held_beat  (held_beat),
    .consume    (consume)
  );

  cfdec_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held_beat  (held_beat),
    .consume    (consume),
    .out_space  (out_space),
    .res_load   (res_load),
    .res        (res)
  );

  cfdec_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_space (out_space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (m_res)
  );

  assign m_tdata = {2'b00, m_res.status, m_res.line_end, m_res.row_index,
                    m_res.run_length, m_res.color_index};
  assign m_tuser = m_res.item_kind;
  assign m_tlast = m_res.frame_end;

endmodule
`default_nettype wire

// ===== tb/sv/cel_frame_rle_decoder_unit_tb.sv =====
// Self-checking testbench for the run-length sprite frame decoder.
`timescale 1ns / 1ps
module cel_frame_rle_decoder_unit_tb
  import cfdec_pkg::*;
();

  // Tracks the decoder state for every accepted byte and holds the
  // result beats that are still due on the output stream.
  class sprite_decode_checker;
    logic [10:0] width_reg;
    bit          clipped_reg;
    phase_t      phase;
    logic [7:0]  hdr_low;
    logic [15:0] pos;
    logic [15:0] start_off;
    logic [6:0]  lit_left;
    int unsigned col;
    logic [9:0]  row;
    status_t     err;
    result_t     pending[$];
    int unsigned mismatches;

    function new();
      width_reg = FRAME_WIDTH_RESET;
      clipped_reg = 1'b0;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase = PH_START;
      hdr_low = '0;
      pos = '0;
      start_off = '0;
      lit_left = '0;
      col = 0;
      row = '0;
      err = ST_OK;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_FRAME_WIDTH) begin
        width_reg = val;
      end else if (idx == CFG_CLIPPED_MODE) begin
        clipped_reg = val[0];
      end
    endfunction

    function int unsigned line_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    // A line only closes on the last pixel of a run or of a literal group.
    function bit place_pixels(input int unsigned n, input bit closes, output bit ends);
      int unsigned nc;
      nc = col + n;
      ends = 1'b0;
      if (nc > line_width()) return 1'b0;
      col = nc;
      if (closes && nc == line_width()) begin
        ends = 1'b1;
        col = 0;
        if (row < MAX_ROWS - 1) row++;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [7:0] b, bit last);
      result_t r;
      bit emit;
      bit ctrl;
      bit ends;
      logic [15:0] off;
      r.item_kind = KIND_NONE;
      r.color_index = '0;
      r.run_length = '0;
      r.row_index = row;
      r.line_end = 1'b0;
      r.frame_end = last;
      r.status = ST_OK;
      emit = 1'b0;
      ctrl = 1'b0;
      ends = 1'b0;
      case (phase)
        PH_START: begin
          if (clipped_reg) begin
            hdr_low = b;
            pos = 16'd1;
            phase = PH_HDR_HIGH;
          end else begin
            ctrl = 1'b1;
          end
        end
        PH_HDR_HIGH: begin
          off = {b, hdr_low};
          if (off < MIN_DATA_OFFSET) off = MIN_DATA_OFFSET;
          start_off = off;
          pos = 16'd2;
          phase = (off == MIN_DATA_OFFSET) ? PH_CTRL : PH_SKIP;
        end
        PH_SKIP: begin
          pos = pos + 16'd1;
          if (pos >= start_off) phase = PH_CTRL;
        end
        PH_CTRL: ctrl = 1'b1;
        PH_LIT: begin
          lit_left = lit_left - 7'd1;
          emit = 1'b1;
          if (place_pixels(1, lit_left == 0, ends)) begin
            r.item_kind = KIND_COLOR;
            r.color_index = b;
            r.run_length = 8'd1;
            if (lit_left == 0) phase = PH_CTRL;
          end else begin
            r.status = ST_OVERFLOW;
            err = ST_OVERFLOW;
            phase = PH_ERR;
          end
        end
        default: ;
      endcase
      if (ctrl) begin
        phase = PH_CTRL;
        if (b > CTRL_LITERAL_MAX) begin
          emit = 1'b1;
          if (place_pixels(256 - b, 1'b1, ends)) begin
            r.item_kind = KIND_RUN;
            r.run_length = 8'(256 - b);
          end else begin
            r.status = ST_OVERFLOW;
            err = ST_OVERFLOW;
            phase = PH_ERR;
          end
        end else if (b == CTRL_ZERO) begin
          emit = 1'b1;
          r.status = ST_ZERO_COUNT;
        end else begin
          lit_left = b[6:0];
          phase = PH_LIT;
        end
      end
      r.line_end = ends;
      if (last) begin
        emit = 1'b1;
        if (phase == PH_ERR) r.status = err;
        else if (phase == PH_LIT) r.status = ST_TRUNCATED;
        else if (phase == PH_CTRL && col != 0) r.status = ST_INCOMPLETE;
        clear_frame();
      end
      if (emit) pending.insert(pending.size(), r);
    endfunction

    function string beat_text(result_t r);
      return $sformatf("kind=%0d color=%02h run=%0d row=%0d line_end=%0b frame_end=%0b status=%0d",
                       r.item_kind, r.color_index, r.run_length, r.row_index,
                       r.line_end, r.frame_end, r.status);
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual %s", $time, beat_text(got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: beat mismatch, expected %s, actual %s", $time,
                 beat_text(want), beat_text(got));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned bytes_sent;
  in_beat_t    frame_bytes[$];

  sprite_decode_checker sb = new();

  cel_frame_rle_decoder_unit uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    m_tready = rx_quiet || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin : watch
    result_t seen;
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        seen.item_kind = kind_t'(m_tuser);
        seen.color_index = m_tdata[7:0];
        seen.run_length = m_tdata[15:8];
        seen.row_index = m_tdata[25:16];
        seen.line_end = m_tdata[26];
        seen.frame_end = m_tlast;
        seen.status = status_t'(m_tdata[29:27]);
        sb.check_beat(seen);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input bit last);
    @(negedge clk);
    while (!tx_quiet && $urandom_range(0, 99) < 36) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), '{data_byte: b, last_byte: 1'b0});
  endtask

  task automatic send_frame();
    frame_bytes[$].last_byte = 1'b1;
    foreach (frame_bytes[i]) push_byte(frame_bytes[i].data_byte, frame_bytes[i].last_byte);
    frame_bytes.delete();
  endtask

  // Holds the stream until every pending beat has drained.
  task automatic settle(input int unsigned tail);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Mostly well-formed lines with random content; some frames break off
  // with noise, a truncated literal group or a partial line.
  task automatic build_frame(input bit hdr, input int unsigned w);
    int unsigned col;
    int unsigned n;
    int unsigned room;
    int unsigned cap;
    int unsigned pick;
    int unsigned lines;
    int unsigned data_at;
    logic [15:0] off;
    bit broken;
    broken = 1'b0;
    if (hdr) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) off = 16'($urandom_range(0, 1));
      else if (pick == 1) off = 16'($urandom);
      else off = 16'($urandom_range(2, 9));
      add_byte(off[7:0]);
      if (pick == 1) begin
        // Frame stops inside the header or the skipped area.
        n = $urandom_range(0, 4);
        if (n != 0) add_byte(off[15:8]);
        for (int i = 1; i < n; i++) add_byte(8'($urandom));
        return;
      end
      add_byte(off[15:8]);
      data_at = (off < 2) ? 2 : off;
      for (int i = 2; i < data_at; i++) add_byte(8'($urandom));
    end
    lines = (w > 64) ? 1 : $urandom_range(1, 4);
    for (int ln = 0; ln < lines && !broken; ln++) begin
      col = 0;
      while (col < w && !broken) begin
        room = w - col;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          add_byte(CTRL_ZERO);
        end else if (pick < 6) begin
          broken = 1'b1;
          repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        end else if (pick < 50) begin
          n = $urandom_range(1, (room < 128) ? room : 128);
          add_byte(8'(256 - n));
          col += n;
        end else begin
          cap = ($urandom_range(0, 9) == 0) ? 127 : 8;
          if (cap > room) cap = room;
          n = $urandom_range(1, cap);
          add_byte(n[7:0]);
          repeat (n) add_byte(8'($urandom));
          col += n;
        end
      end
    end
    pick = $urandom_range(0, 9);
    if (!broken && pick == 0) begin
      n = $urandom_range(2, 20);
      add_byte(n[7:0]);
      repeat ($urandom_range(0, n - 1)) add_byte(8'($urandom));
    end else if (!broken && pick == 1) begin
      add_byte(8'hFF);
    end
    if (frame_bytes.size() == 0) add_byte(8'($urandom));
  endtask

  initial begin
    logic [10:0] wr;
    bit          clip;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: zero count, a full line, a literal pair, then an
    // unfinished line at the end of the frame.
    add_byte(8'h00); add_byte(8'hE0); add_byte(8'h02);
    add_byte(8'hA5); add_byte(8'h5A); add_byte(8'hFF);
    send_frame();
    settle(4);

    // Widest line, header with an offset below the minimum, the longest
    // run, and a literal group cut short by the end of the frame.
    write_reg(CFG_FRAME_WIDTH, 11'h7FF);
    write_reg(CFG_CLIPPED_MODE, 11'd1);
    add_byte(8'h01); add_byte(8'h00); add_byte(8'h80); add_byte(8'h01);
    add_byte(8'hFF); add_byte(8'h7F); add_byte(8'h3C); add_byte(8'hC3);
    send_frame();
    settle(4);

    // Zero width counts as one: skipped bytes, a full line, then a run that
    // overflows and bytes dropped until the end; next a frame that ends in its header.
    write_reg(CFG_FRAME_WIDTH, 11'd0);
    add_byte(8'h04); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h00);
    add_byte(8'hFF); add_byte(8'hFE); add_byte(8'h12); add_byte(8'h34);
    send_frame();
    add_byte(8'h00); add_byte(8'hFF);
    send_frame();
    settle(4);

    // A literal pixel after the line is already full.
    write_reg(CFG_CLIPPED_MODE, 11'd0);
    add_byte(8'h02); add_byte(8'h11); add_byte(8'h22); add_byte(8'h00);
    send_frame();
    settle(4);

    // Enough one-pixel lines to run the row counter into its limit.
    write_reg(CFG_FRAME_WIDTH, 11'd1);
    repeat (1030) add_byte(8'hFF);
    send_frame();
    settle(4);

    while (bytes_sent < 1300) begin
      tx_quiet = (bytes_sent >= 1100 && bytes_sent < 1200);
      rx_quiet = tx_quiet;
      case ($urandom_range(0, 19))
        0: wr = 11'd0;
        1: wr = 11'h7FF;
        2: wr = 11'd1024;
        3: wr = 11'd1;
        4: wr = 11'($urandom);
        default: wr = 11'($urandom_range(2, 40));
      endcase
      clip = 1'($urandom_range(0, 1));
      write_reg(CFG_FRAME_WIDTH, wr);
      write_reg(CFG_CLIPPED_MODE, {10'd0, clip});
      repeat ($urandom_range(1, 3)) begin
        build_frame(clip, sb.line_width());
        send_frame();
      end
      settle(4);
    end

    settle(10);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
